// ----- design/bmeter_pkg.sv -----
// Package for the spectrum band peak meter.
// Payload structs, queue entry type, opcodes and widths; no dependencies.
package bmeter_pkg;

   localparam int MAX_BARS_DEF = 32;
   localparam int MAG_W        = 24;
   localparam int SUM_W        = 33;
   localparam int CNT_W        = 10;
   localparam int BP_W         = 9;
   localparam int LEVEL_STEPS  = 185;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [1:0] OP_BIN   = 2'd0;
   localparam logic [1:0] OP_TABLE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [23:0] bin_value;
      logic        last_bin;
      logic [5:0]  table_index;
      logic [8:0]  table_value;
   } req_type;

   typedef struct packed {
      logic [4:0]  bar_index;
      logic [7:0]  level;
      logic [23:0] band_mean;
      logic        last_bar;
   } rsp_type;

   typedef struct packed {
      logic             clear;
      logic [4:0]       bar;
      logic             last_bar;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } job_type;

endpackage

// ----- design/bmeter_front.sv -----
// Front end: accepts requests, keeps the breakpoint table and the band accumulator.
// Pushes band-close and peak-clear jobs to the queue. Uses bmeter_pkg.
module bmeter_front #(
   parameter int MAX_BARS = bmeter_pkg::MAX_BARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bmeter_pkg::req_type req_data,
   input  logic [5:0]        num_bars,
   input  logic              q_full,
   output logic              q_push,
   output bmeter_pkg::job_type q_data
);
   import bmeter_pkg::*;

   localparam int BW = $clog2(MAX_BARS + 1);
   localparam int IW = $clog2(MAX_BARS);

   // entry 0 on its own; tab_ff[i] holds breakpoint entry i+1
   logic [BP_W-1:0]  bp0_ff;
   logic [BP_W-1:0]  tab_ff [MAX_BARS];
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [BW-1:0]    band_ff, band_in;

   logic             acc;
   logic [6:0]       nb;
   logic             active;
   logic [IW-1:0]    lo_idx, hi_idx;
   logic [CNT_W-1:0] lo, hi;
   logic [SUM_W:0]   sum_add;
   logic [SUM_W-1:0] sum_new;
   logic             close;

   assign req_ready = !q_full;
   assign acc = req_valid && req_ready;

   always_comb begin
      nb = (7'(num_bars) > 7'(MAX_BARS)) ? 7'(MAX_BARS) : 7'(num_bars);
      active = 7'(band_ff) < nb;
      lo_idx = IW'(band_ff - BW'(1));
      hi_idx = band_ff[IW-1:0];
      lo = (band_ff == '0) ? CNT_W'(bp0_ff) : CNT_W'(tab_ff[lo_idx]) + CNT_W'(1);
      hi = CNT_W'(tab_ff[hi_idx]);
      sum_add = {1'b0, sum_ff} + (SUM_W+1)'(req_data.bin_value);
      sum_new = sum_ff;
      if (active && cnt_ff >= lo && cnt_ff <= hi)
         sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      close = active && cnt_ff == hi && hi >= lo;

      q_push = 1'b0;
      q_data.clear = 1'b0;
      q_data.bar = 5'(band_ff);
      q_data.last_bar = (7'(band_ff) + 7'd1) == nb;
      q_data.sum = sum_new;
      q_data.count = hi - lo + CNT_W'(1);

      sum_in = sum_ff;
      cnt_in = cnt_ff;
      band_in = band_ff;
      if (acc) begin
         case (req_data.opcode)
            OP_BIN: begin
               sum_in = sum_new;
               if (close) begin
                  q_push = 1'b1;
                  band_in = band_ff + BW'(1);
                  sum_in = '0;
               end
               if (req_data.last_bin) begin
                  cnt_in = '0;
                  band_in = '0;
                  sum_in = '0;
               end else if (cnt_ff != {CNT_W{1'b1}}) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            OP_CLEAR: begin
               q_push = 1'b1;
               q_data.clear = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         band_ff <= '0;
         bp0_ff <= '0;
         for (int i = 0; i < MAX_BARS; i++) tab_ff[i] <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         band_ff <= band_in;
         if (acc && req_data.opcode == OP_TABLE) begin
            if (req_data.table_index == '0)
               bp0_ff <= req_data.table_value;
            else if (7'(req_data.table_index) <= 7'(MAX_BARS))
               tab_ff[IW'(req_data.table_index - 6'd1)] <= req_data.table_value;
         end
      end
   end
endmodule

// ----- design/bmeter_fifo.sv -----
// Short job queue between front and back end.
// Uses bmeter_pkg for the entry type.
module bmeter_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bmeter_pkg::job_type push_data,
   input  logic               pop,
   output bmeter_pkg::job_type pop_data,
   output logic               full,
   output logic               empty
);
   import bmeter_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   job_type       mem_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   fill_ff;

   assign full = fill_ff == (AW+1)'(QUEUE_DEPTH);
   assign empty = fill_ff == '0;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push && !full) wr_ff <= wr_ff + AW'(1);
         if (pop && !empty) rd_ff <= rd_ff + AW'(1);
         fill_ff <= fill_ff + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
      end
   end
endmodule

// ----- design/bmeter_div.sv -----
// Restoring divider, one quotient bit per cycle, 33-bit dividend by 24-bit divisor.
// Uses bmeter_pkg for widths.
module bmeter_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bmeter_pkg::SUM_W-1:0] dividend,
   input  logic [bmeter_pkg::MAG_W-1:0] divisor,
   output logic                        done,
   output logic [bmeter_pkg::SUM_W-1:0] quotient
);
   import bmeter_pkg::*;

   logic [SUM_W-1:0] quot_ff;
   logic [MAG_W-1:0] rem_ff, dvs_ff;
   logic [5:0]       cnt_ff;
   logic             done_ff;
   logic [MAG_W:0]   trial;
   logic             bit_q;

   assign done = done_ff;
   assign quotient = quot_ff;

   always_comb begin
      trial = {rem_ff, quot_ff[SUM_W-1]};
      bit_q = trial >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= cnt_ff == 6'd1;
         if (start) cnt_ff <= 6'(SUM_W);
         else if (cnt_ff != '0) cnt_ff <= cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quot_ff <= {quot_ff[SUM_W-2:0], bit_q};
         rem_ff <= bit_q ? MAG_W'(trial - {1'b0, dvs_ff}) : trial[MAG_W-1:0];
      end
   end
endmodule

// ----- design/bmeter_back.sv -----
// Back end: pops jobs, forms the band mean, updates peak hold and the level.
// Uses bmeter_pkg and bmeter_div.
module bmeter_back #(
   parameter int MAX_BARS = bmeter_pkg::MAX_BARS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  bmeter_pkg::job_type q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bmeter_pkg::rsp_type rsp_data
);
   import bmeter_pkg::*;

   localparam int IW = $clog2(MAX_BARS);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MEAN  = 5'b00010,
      ST_PEAK  = 5'b00100,
      ST_LEVEL = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   job_type          job_ff;
   logic [MAG_W-1:0] peak_ff [MAX_BARS];
   logic [MAX_BARS-1:0] pvld_ff;
   logic [MAG_W-1:0] mean_ff, top_ff, mean_c, top_c, old_pk;
   logic [7:0]       level_ff;
   logic             start;
   logic [SUM_W-1:0] dvd, quot;
   logic [MAG_W-1:0] dvs;
   logic             done;
   logic [IW-1:0]    idx;
   logic [31:0]      prod;

   assign idx = job_ff.bar[IW-1:0];
   assign q_pop = state_ff == ST_IDLE && !q_empty;
   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_data = '{bar_index: job_ff.bar, level: level_ff,
                       band_mean: mean_ff, last_bar: job_ff.last_bar};

   bmeter_div u_div (
      .clock(clock), .reset(reset), .start(start), .dividend(dvd),
      .divisor(dvs), .done(done), .quotient(quot)
   );

   always_comb begin
      mean_c = (quot > SUM_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : quot[MAG_W-1:0];
      old_pk = pvld_ff[idx] ? peak_ff[idx] : '0;
      top_c = (old_pk > mean_c) ? old_pk : mean_c;
      prod = 32'(mean_ff) * 32'(LEVEL_STEPS);
      state_in = state_ff;
      start = 1'b0;
      dvd = SUM_W'(prod);
      dvs = top_ff;
      case (state_ff)
         ST_IDLE: begin
            dvd = q_data.sum;
            dvs = MAG_W'(q_data.count);
            if (!q_empty && !q_data.clear) begin
               start = 1'b1;
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: if (done) state_in = ST_PEAK;
         ST_PEAK: begin
            if (top_ff == '0) state_in = ST_OUT;
            else begin
               start = 1'b1;
               state_in = ST_LEVEL;
            end
         end
         ST_LEVEL: if (done) state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pvld_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (q_pop && q_data.clear) pvld_ff <= '0;
         if (state_ff == ST_MEAN && done) pvld_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) job_ff <= q_data;
      if (state_ff == ST_MEAN && done) begin
         mean_ff <= mean_c;
         top_ff <= top_c;
         peak_ff[idx] <= top_c;
      end
      if (state_ff == ST_PEAK) level_ff <= '0;
      if (state_ff == ST_LEVEL && done) level_ff <= quot[7:0];
   end
endmodule

// ----- design/spectrum_band_peak_meter.sv -----
// Top level of the spectrum band peak meter.
// Holds the num_bars register; instantiates bmeter_front, bmeter_fifo, bmeter_back.
//
// Usage: FFT magnitude bins enter on req_* (opcode 0) in index order, last_bin
// marking the frame end. Opcode 1 writes a breakpoint entry, opcode 2 clears
// all peak-hold registers. Each closed band yields one rsp_* result with the
// band mean, the level mean*185/peak and the band index.
// csr_* writes num_bars; it is always ready.
// Each band result comes from two serial divisions in the back end: the mean,
// then the level, which is skipped when the peak is zero.
// Non-closing requests are taken one per cycle while the job queue is not full;
// the back end handles one job at a time, and the 4-entry job queue absorbs bursts.
// Reset clears the breakpoint table, peaks, accumulator and num_bars to 32.
// A stalled rsp_ready holds the result; the front keeps accepting requests
// until the queue fills, then drops req_ready.
module spectrum_band_peak_meter #(
   parameter int MAX_BARS = bmeter_pkg::MAX_BARS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bmeter_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bmeter_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [5:0]          csr_wdata
);
   import bmeter_pkg::*;

   logic [5:0] num_bars_ff;
   logic       q_full, q_empty, q_push, q_pop;
   job_type    push_data, pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) num_bars_ff <= 6'd32;
      else if (csr_valid) num_bars_ff <= csr_wdata;
   end

   bmeter_front #(.MAX_BARS(MAX_BARS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .num_bars(num_bars_ff), .q_full(q_full),
      .q_push(q_push), .q_data(push_data)
   );

   bmeter_fifo u_fifo (
      .clock(clock), .reset(reset), .push(q_push), .push_data(push_data),
      .pop(q_pop), .pop_data(pop_data), .full(q_full), .empty(q_empty)
   );

   bmeter_back #(.MAX_BARS(MAX_BARS)) u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_data(pop_data),
      .q_pop(q_pop), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

`ifndef ASSERT_OFF
   a_level_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.level <= 8'(LEVEL_STEPS))
      else $error("level above full scale");
   a_level_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.band_mean == '0 |-> rsp_data.level == '0)
      else $error("nonzero level for zero mean");
   a_no_ovf: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_ready)
      else $error("request taken with full queue");
`endif
endmodule

// ----- dv/spectrum_band_peak_meter_tb.sv -----
// Testbench for the spectrum band peak meter: drives bins, table writes and peak
// clears, predicts band means, levels and peaks, and checks every result in order.
// Depends on bmeter_pkg and spectrum_band_peak_meter.
module spectrum_band_peak_meter_tb;
   import bmeter_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [5:0] csr_wdata = '0;

   spectrum_band_peak_meter u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [5:0]  bars_reg;
   logic [8:0]  bp_tab [0:32];
   logic [23:0] peak_tab [0:31];
   logic [32:0] acc_sum;
   logic [9:0]  bin_idx;
   logic [5:0]  band_now;

   req_type pending_reqs[$];
   rsp_type band_results[$];
   int      errors = 0;
   bit      hold_req = 1'b0;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic predict_band(input req_type r);
      logic [5:0]  nb;
      logic [9:0]  lo, hi;
      logic [33:0] s;
      logic [32:0] mean;
      logic [63:0] lvl;
      rsp_type     o;
      if (r.opcode == OP_TABLE) begin
         if (r.table_index <= 32) bp_tab[r.table_index] = r.table_value;
         return;
      end
      if (r.opcode == OP_CLEAR) begin
         for (int i = 0; i < 32; i++) peak_tab[i] = '0;
         return;
      end
      if (r.opcode != OP_BIN) return;
      nb = (bars_reg > 32) ? 6'd32 : bars_reg;
      if (band_now < nb && band_now < 32) begin
         lo = (band_now == 0) ? {1'b0, bp_tab[0]} : {1'b0, bp_tab[band_now]} + 10'd1;
         hi = {1'b0, bp_tab[band_now + 1]};
         if (bin_idx >= lo && bin_idx <= hi) begin
            s = {1'b0, acc_sum} + r.bin_value;
            acc_sum = s[33] ? {33{1'b1}} : s[32:0];
         end
         if (bin_idx == hi && hi >= lo) begin
            mean = acc_sum / (hi - lo + 33'd1);
            if (mean > 33'hFFFFFF) mean = 33'hFFFFFF;
            if (peak_tab[band_now] < mean[23:0]) peak_tab[band_now] = mean[23:0];
            lvl = (peak_tab[band_now] == 0) ? 64'd0
                : (64'(mean) * LEVEL_STEPS) / peak_tab[band_now];
            if (lvl > LEVEL_STEPS) lvl = LEVEL_STEPS;
            o.bar_index = band_now[4:0];
            o.level     = lvl[7:0];
            o.band_mean = mean[23:0];
            o.last_bar  = (band_now + 6'd1 == nb);
            band_results.push_back(o);
            band_now = band_now + 6'd1;
            acc_sum  = '0;
         end
      end
      if (r.last_bin) begin
         bin_idx = '0; band_now = '0; acc_sum = '0;
      end else if (bin_idx < 10'd1023) begin
         bin_idx = bin_idx + 10'd1;
      end
   endtask

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) predict_band(req_data);
         if (req_valid && !req_ready) begin
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 &&
                      !(hold_req && band_results.size() > 0)) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_gap   <= gap_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (band_results.size() == 0) begin
               $error("unexpected result bar_index=%0d", rsp_data.bar_index);
               errors++;
            end else begin
               rsp_type e;
               e = band_results.pop_front();
               if (e.bar_index !== rsp_data.bar_index) begin
                  $error("bar_index exp %0d got %0d", e.bar_index, rsp_data.bar_index);
                  errors++;
               end
               if (e.level !== rsp_data.level) begin
                  $error("level exp %0d got %0d", e.level, rsp_data.level);
                  errors++;
               end
               if (e.band_mean !== rsp_data.band_mean) begin
                  $error("band_mean exp %0d got %0d", e.band_mean, rsp_data.band_mean);
                  errors++;
               end
               if (e.last_bar !== rsp_data.last_bar) begin
                  $error("last_bar exp %0d got %0d", e.last_bar, rsp_data.last_bar);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_gap <= gap_len();
         end
      end
   end

   function automatic req_type mk_bin(input logic [23:0] v, input logic l);
      req_type r;
      r = '0;
      r.opcode = OP_BIN; r.bin_value = v; r.last_bin = l;
      r.table_index = 6'($urandom); r.table_value = 9'($urandom);
      return r;
   endfunction

   function automatic req_type mk_table(input logic [5:0] i, input logic [8:0] v);
      req_type r;
      r = '0;
      r.opcode = OP_TABLE; r.table_index = i; r.table_value = v;
      r.bin_value = 24'($urandom); r.last_bin = 1'($urandom);
      return r;
   endfunction

   function automatic req_type mk_op(input logic [1:0] op);
      req_type r;
      r = req_type'(42'({$urandom, $urandom}));
      r.opcode = op;
      return r;
   endfunction

   task automatic drain();
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      while (band_results.size() > 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_bars(input logic [5:0] v);
      @(posedge clock);
      csr_wdata <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      bars_reg = v;
   endtask

   function automatic logic [23:0] rand_mag();
      case ($urandom_range(0, 3))
         0: return 24'hFFFFFF;
         1: return 24'($urandom_range(0, 15));
         default: return 24'($urandom);
      endcase
   endfunction

   // one frame over a random breakpoint layout; widths are kept small
   task automatic queue_frame(input int nb);
      int bp;
      int span;
      bp = $urandom_range(0, 3);
      pending_reqs.push_back(mk_table(6'd0, 9'(bp)));
      for (int b = 1; b <= nb; b++) begin
         bp = bp + $urandom_range(1, 4);
         pending_reqs.push_back(mk_table(6'(b), 9'(bp)));
      end
      span = bp + $urandom_range(0, 3);
      for (int i = 0; i <= span; i++)
         pending_reqs.push_back(mk_bin(rand_mag(), i == span));
   endtask

   initial begin
      bars_reg = 6'd32;
      for (int i = 0; i < 33; i++) bp_tab[i] = '0;
      for (int i = 0; i < 32; i++) peak_tab[i] = '0;
      acc_sum = '0; bin_idx = '0; band_now = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset table gives band 0 = bin 0 only, later bands never close
      pending_reqs.push_back(mk_bin(24'hFFFFFF, 1'b0));
      pending_reqs.push_back(mk_bin(24'h0, 1'b1));
      pending_reqs.push_back(mk_table(6'd1, 9'd2));
      pending_reqs.push_back(mk_table(6'd2, 9'd1));     // non-increasing
      pending_reqs.push_back(mk_table(6'd33, 9'h1FF));  // out of range
      pending_reqs.push_back(mk_table(6'd63, 9'h1FF));
      pending_reqs.push_back(mk_op(2'd3));
      for (int i = 0; i < 5; i++) pending_reqs.push_back(mk_bin(24'hFFFFFF, i == 4));
      pending_reqs.push_back(mk_op(OP_CLEAR));
      for (int i = 0; i < 5; i++) pending_reqs.push_back(mk_bin(24'h0, i == 4));
      pending_reqs.push_back(mk_table(6'd32, 9'h1FF));
      pending_reqs.push_back(mk_bin(24'h000001, 1'b1));
      drain();

      write_bars(6'd1);
      queue_frame(1);
      drain();
      write_bars(6'd0);
      queue_frame(3);
      drain();
      write_bars(6'd63);
      queue_frame(32);
      drain();

      // pause the sender until every band result is back
      write_bars(6'd4);
      queue_frame(4);
      hold_req = 1'b1;
      drain();
      hold_req = 1'b0;
      queue_frame(4);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         logic [5:0] nbv;
         nbv = (ph == 0) ? 6'd32 : (ph == 1) ? 6'd1 : 6'($urandom_range(1, 12));
         write_bars(nbv);
         for (int f = 0; f < 4; f++) begin
            queue_frame((nbv > 32) ? 32 : nbv);
            if ($urandom_range(0, 4) == 0) pending_reqs.push_back(mk_op(OP_CLEAR));
            if ($urandom_range(0, 9) == 0) pending_reqs.push_back(mk_op(2'd3));
            if ($urandom_range(0, 9) == 0)
               pending_reqs.push_back(mk_table(6'($urandom_range(0, 63)), 9'($urandom)));
         end
         drain();
      end
      if (errors == 0)
         $display("spectrum_band_peak_meter_tb: done, clean");
      else
         $display("spectrum_band_peak_meter_tb: done, errors");
      $finish;
   end

   initial begin
      #4000000;
      $display("spectrum_band_peak_meter_tb: done, errors");
      $finish;
   end
endmodule
